[src/tccd_pkg.sv]
// Package for the terminal control-code decoder: field widths, display
// operation codes, escape-sequence codes, character codes and the shared types.
// No dependencies.
`timescale 1ns / 1ps

package tccd_pkg;

	localparam int ROW_W    = 5;
	localparam int COL_W    = 7;
	localparam int DEF_ROWS = 24;
	localparam int DEF_COLS = 80;

	// Display operations.
	localparam logic [3:0] OP_NONE        = 4'd0;
	localparam logic [3:0] OP_PRINT       = 4'd1;
	localparam logic [3:0] OP_PRINT_SCROLL = 4'd2;
	localparam logic [3:0] OP_BELL        = 4'd3;
	localparam logic [3:0] OP_CLEAR       = 4'd4;
	localparam logic [3:0] OP_SCROLL_UP   = 4'd5;
	localparam logic [3:0] OP_SCROLL_DOWN = 4'd6;
	localparam logic [3:0] OP_DEL_LINE    = 4'd7;
	localparam logic [3:0] OP_INS_LINE    = 4'd8;
	localparam logic [3:0] OP_ERASE_EOL   = 4'd9;
	localparam logic [3:0] OP_ERASE_EOS   = 4'd10;
	localparam logic [3:0] OP_MOVE        = 4'd11;

	// Escape-sequence progress: number of bytes of the sequence taken so far.
	localparam logic [2:0] ESC_IDLE   = 3'd0;
	localparam logic [2:0] ESC_SECOND = 3'd1;
	localparam logic [2:0] ESC_COORD1 = 3'd2;
	localparam logic [2:0] ESC_COORD2 = 3'd3;
	localparam logic [2:0] ESC_PLOT3  = 3'd4;
	localparam logic [2:0] ESC_PLOT4  = 3'd5;

	// Kind of multi-byte escape sequence.
	localparam logic [1:0] KIND_PLOT    = 2'd0;
	localparam logic [1:0] KIND_ADDR_RC = 2'd1;
	localparam logic [1:0] KIND_ADDR_CR = 2'd2;

	// Control characters.
	localparam logic [6:0] CH_CURSOR_OFF = 7'h05;
	localparam logic [6:0] CH_BELL       = 7'h07;
	localparam logic [6:0] CH_BS         = 7'h08;
	localparam logic [6:0] CH_LF         = 7'h0A;
	localparam logic [6:0] CH_FF         = 7'h0C;
	localparam logic [6:0] CH_CR         = 7'h0D;
	localparam logic [6:0] CH_SCROLL_UP  = 7'h0E;
	localparam logic [6:0] CH_SCROLL_DN  = 7'h0F;
	localparam logic [6:0] CH_UP         = 7'h11;
	localparam logic [6:0] CH_DOWN       = 7'h12;
	localparam logic [6:0] CH_RIGHT      = 7'h13;
	localparam logic [6:0] CH_LEFT       = 7'h14;
	localparam logic [6:0] CH_CURSOR_ON  = 7'h15;
	localparam logic [6:0] CH_ESC        = 7'h1B;
	localparam logic [6:0] CH_HOME       = 7'h1C;
	localparam logic [6:0] CH_SPACE      = 7'h20;
	localparam logic [6:0] CH_DEL        = 7'h7F;

	// Second byte of an escape sequence.
	localparam logic [6:0] EC_PLOT     = 7'h41; // A
	localparam logic [6:0] EC_ADDR_RC  = 7'h45; // E
	localparam logic [6:0] EC_ADDR_CR  = 7'h3D; // =
	localparam logic [6:0] EC_DEL_LINE = 7'h42; // B
	localparam logic [6:0] EC_INS_LINE = 7'h43; // C
	localparam logic [6:0] EC_NAT_ON   = 7'h44; // D
	localparam logic [6:0] EC_NAT_OFF  = 7'h49; // I
	localparam logic [6:0] EC_EOL_K    = 7'h4B; // K
	localparam logic [6:0] EC_EOL_L    = 7'h4C; // L
	localparam logic [6:0] EC_REV_ON   = 7'h50; // P
	localparam logic [6:0] EC_REV_OFF  = 7'h51; // Q
	localparam logic [6:0] EC_EOS_S    = 7'h53; // S
	localparam logic [6:0] EC_EOS_Z    = 7'h5A; // Z
	localparam logic [6:0] EC_EOS_K    = 7'h6B; // k
	localparam logic [6:0] EC_REV_ON_L = 7'h70; // p
	localparam logic [6:0] EC_REV_OFF_L = 7'h71; // q

	localparam logic [7:0] GLYPH_NATIONAL_BASE = 8'd128;
	localparam logic [7:0] GLYPH_ARROW         = 8'd135;
	localparam logic [6:0] COORD_OFFSET        = 7'd32;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             rev;
		logic             natl;
		logic             cur_en;
		logic [2:0]       esc_count;
		logic [1:0]       esc_kind;
		logic [6:0]       first_coord;
	} state_t;

	typedef struct packed {
		logic [3:0]       op;
		logic [7:0]       glyph;
		logic             rev;
		logic [ROW_W-1:0] trow;
		logic [COL_W-1:0] tcol;
		logic [ROW_W-1:0] new_row;
		logic [COL_W-1:0] new_col;
		logic             shown;
	} result_t;

	typedef struct packed {
		logic       hit;
		logic [2:0] idx;
	} natl_t;

	// Position of a character in the national replacement set { | } [ \ ] ~.
	function automatic natl_t national_index(input logic [6:0] v);
		natl_t r;
		r.hit = 1'b1;
		r.idx = 3'd0;
		case (v)
			7'h7B: r.idx = 3'd0;
			7'h7C: r.idx = 3'd1;
			7'h7D: r.idx = 3'd2;
			7'h5B: r.idx = 3'd3;
			7'h5C: r.idx = 3'd4;
			7'h5D: r.idx = 3'd5;
			7'h7E: r.idx = 3'd6;
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

endpackage

[src/terminal_control_code_decoder_unit.sv]
// Top level of the terminal control-code decoder: input register, terminal
// state registers, result register and checks. Depends on tccd_pkg and tccd_decode.
`timescale 1ns / 1ps

// Each byte written to the terminal produces exactly one result transaction
// carrying the display command, its screen position and glyph, and the cursor
// position and visibility after the byte. The block accepts one byte per clock
// cycle while the output side is not stalled; a byte is captured in an input
// register and its result is loaded into the output register once that register
// is empty or being read. The terminal state (cursor, video flags, escape
// progress) updates when a byte moves from the input register into the output
// register. drop_nul is written through cfg_we/cfg_wdata; the user must write it
// only while idle, as the block itself does not enforce this.
module terminal_control_code_decoder_unit #(
	parameter int SCREEN_ROWS = tccd_pkg::DEF_ROWS,
	parameter int SCREEN_COLS = tccd_pkg::DEF_COLS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   data_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [3:0]                   display_op,
	output logic [7:0]                   glyph_code,
	output logic                         glyph_reverse,
	output logic [tccd_pkg::ROW_W-1:0]   target_row,
	output logic [tccd_pkg::COL_W-1:0]   target_col,
	output logic [tccd_pkg::ROW_W-1:0]   new_cursor_row,
	output logic [tccd_pkg::COL_W-1:0]   new_cursor_col,
	output logic                         cursor_shown
);

	logic              drop_nul_q;
	logic              valid_s1;
	logic [7:0]        data_s1;
	logic              out_valid_q;
	tccd_pkg::result_t res_q;
	tccd_pkg::state_t  state_q;
	tccd_pkg::state_t  state_nxt;
	tccd_pkg::result_t res_nxt;
	logic              advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	tccd_decode #(
		.SCREEN_ROWS(SCREEN_ROWS),
		.SCREEN_COLS(SCREEN_COLS)
	) u_decode (
		.cur      (state_q),
		.data     (data_s1),
		.drop_nul (drop_nul_q),
		.nxt      (state_nxt),
		.res      (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_nul_q <= 1'b0;
		end else if (cfg_we) begin
			drop_nul_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '{row: '0, col: '0, rev: 1'b0, natl: 1'b0, cur_en: 1'b1,
			                 esc_count: tccd_pkg::ESC_IDLE, esc_kind: tccd_pkg::KIND_PLOT,
			                 first_coord: '0};
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance) begin
				out_valid_q <= 1'b1;
				state_q     <= state_nxt;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			data_s1 <= data_byte;
		if (advance)
			res_q <= res_nxt;
	end

	assign out_valid      = out_valid_q;
	assign display_op     = res_q.op;
	assign glyph_code     = res_q.glyph;
	assign glyph_reverse  = res_q.rev;
	assign target_row     = res_q.trow;
	assign target_col     = res_q.tcol;
	assign new_cursor_row = res_q.new_row;
	assign new_cursor_col = res_q.new_col;
	assign cursor_shown   = res_q.shown;

	// The reported cursor always matches the live terminal state.
	a_cursor_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.new_row == state_q.row && res_q.new_col == state_q.col &&
		                 res_q.shown == (state_q.cur_en &&
		                                 state_q.esc_count == tccd_pkg::ESC_IDLE)))
		else $error("reported cursor differs from terminal state");

	// The cursor never leaves the screen.
	a_cursor_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, state_q.row} < (tccd_pkg::ROW_W + 1)'(SCREEN_ROWS)) &&
		({1'b0, state_q.col} < (tccd_pkg::COL_W + 1)'(SCREEN_COLS)))
		else $error("cursor outside the screen");

	// Only print commands carry a glyph or the reverse flag.
	a_glyph_only_on_print: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.op != tccd_pkg::OP_PRINT &&
		 res_q.op != tccd_pkg::OP_PRINT_SCROLL) |-> (res_q.glyph == 8'd0 && !res_q.rev))
		else $error("glyph on a non-print command");

	// Terminal state changes only when a byte is decoded.
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("terminal state changed without a decoded byte");

endmodule

[src/tccd_decode.sv]
// Combinational decoder for one terminal byte: next terminal state and the
// display command. Depends on tccd_pkg.
`timescale 1ns / 1ps

module tccd_decode #(
	parameter int SCREEN_ROWS = tccd_pkg::DEF_ROWS,
	parameter int SCREEN_COLS = tccd_pkg::DEF_COLS
) (
	input  tccd_pkg::state_t  cur,
	input  logic [7:0]        data,
	input  logic              drop_nul,
	output tccd_pkg::state_t  nxt,
	output tccd_pkg::result_t res
);

	localparam int RW = tccd_pkg::ROW_W;
	localparam int CW = tccd_pkg::COL_W;
	localparam logic [RW-1:0] LAST_ROW   = RW'(SCREEN_ROWS - 1);
	localparam logic [RW:0]   ROWS_X     = (RW + 1)'(SCREEN_ROWS);
	localparam logic [CW:0]   COLS_X     = (CW + 1)'(SCREEN_COLS);
	localparam logic [CW:0]   LAST_COL_X = (CW + 1)'(SCREEN_COLS - 1);
	localparam logic [7:0]    ROWS_8     = 8'(SCREEN_ROWS);
	localparam logic [7:0]    COLS_8     = 8'(SCREEN_COLS);

	logic [6:0]       v;
	logic [RW:0]      row_inc;
	logic [CW:0]      col_inc;
	logic [6:0]       rowb, colb, rowd, cold;
	tccd_pkg::natl_t  nat;

	assign v       = data[6:0];
	assign row_inc = {1'b0, cur.row} + 1'b1;
	assign col_inc = {1'b0, cur.col} + 1'b1;
	assign nat     = tccd_pkg::national_index(v);
	assign rowb    = (cur.esc_kind == tccd_pkg::KIND_ADDR_RC) ? cur.first_coord : v;
	assign colb    = (cur.esc_kind == tccd_pkg::KIND_ADDR_RC) ? v : cur.first_coord;
	assign rowd    = rowb - tccd_pkg::COORD_OFFSET;
	assign cold    = colb - tccd_pkg::COORD_OFFSET;

	always_comb begin
		nxt = cur;
		res = '0;
		if (!(data == 8'd0 && drop_nul)) begin
			if (cur.esc_count != tccd_pkg::ESC_IDLE) begin
				case (cur.esc_count)
					tccd_pkg::ESC_SECOND: begin
						nxt.esc_count = tccd_pkg::ESC_IDLE;
						case (v)
							tccd_pkg::EC_PLOT: begin
								nxt.esc_kind  = tccd_pkg::KIND_PLOT;
								nxt.esc_count = tccd_pkg::ESC_COORD1;
							end
							tccd_pkg::EC_ADDR_RC: begin
								nxt.esc_kind  = tccd_pkg::KIND_ADDR_RC;
								nxt.esc_count = tccd_pkg::ESC_COORD1;
							end
							tccd_pkg::EC_ADDR_CR: begin
								nxt.esc_kind  = tccd_pkg::KIND_ADDR_CR;
								nxt.esc_count = tccd_pkg::ESC_COORD1;
							end
							tccd_pkg::EC_DEL_LINE: begin
								res.op   = tccd_pkg::OP_DEL_LINE;
								res.trow = cur.row;
							end
							tccd_pkg::EC_INS_LINE: begin
								res.op   = tccd_pkg::OP_INS_LINE;
								res.trow = cur.row;
							end
							tccd_pkg::EC_REV_ON, tccd_pkg::EC_REV_ON_L: nxt.rev = 1'b1;
							tccd_pkg::EC_REV_OFF, tccd_pkg::EC_REV_OFF_L: nxt.rev = 1'b0;
							tccd_pkg::EC_EOL_K, tccd_pkg::EC_EOL_L: begin
								res.op   = tccd_pkg::OP_ERASE_EOL;
								res.trow = cur.row;
								res.tcol = cur.col;
							end
							tccd_pkg::EC_EOS_Z, tccd_pkg::EC_EOS_K, tccd_pkg::EC_EOS_S: begin
								res.op   = tccd_pkg::OP_ERASE_EOS;
								res.trow = cur.row;
								res.tcol = cur.col;
							end
							tccd_pkg::EC_NAT_ON: nxt.natl = 1'b1;
							tccd_pkg::EC_NAT_OFF: nxt.natl = 1'b0;
							default: ;
						endcase
					end
					tccd_pkg::ESC_COORD1: begin
						nxt.first_coord = v;
						nxt.esc_count   = tccd_pkg::ESC_COORD2;
					end
					tccd_pkg::ESC_COORD2: begin
						if (cur.esc_kind == tccd_pkg::KIND_ADDR_RC ||
						    cur.esc_kind == tccd_pkg::KIND_ADDR_CR) begin
							// A coordinate that falls off the screen keeps its current value.
							if (rowb >= tccd_pkg::COORD_OFFSET && {1'b0, rowd} < ROWS_8)
								nxt.row = rowd[RW-1:0];
							if (colb >= tccd_pkg::COORD_OFFSET && {1'b0, cold} < COLS_8)
								nxt.col = cold[CW-1:0];
							nxt.esc_count = tccd_pkg::ESC_IDLE;
							res.op   = tccd_pkg::OP_MOVE;
							res.trow = nxt.row;
							res.tcol = nxt.col;
						end else begin
							nxt.esc_count = tccd_pkg::ESC_PLOT3;
						end
					end
					tccd_pkg::ESC_PLOT3: nxt.esc_count = tccd_pkg::ESC_PLOT4;
					default: nxt.esc_count = tccd_pkg::ESC_IDLE;
				endcase
			end else if (v < tccd_pkg::CH_SPACE) begin
				case (v)
					tccd_pkg::CH_CURSOR_OFF: nxt.cur_en = 1'b0;
					tccd_pkg::CH_CURSOR_ON: nxt.cur_en = 1'b1;
					tccd_pkg::CH_BELL: res.op = tccd_pkg::OP_BELL;
					tccd_pkg::CH_BS: begin
						if (cur.col != '0) begin
							nxt.col   = cur.col - 1'b1;
							res.op    = tccd_pkg::OP_PRINT;
							res.glyph = {1'b0, tccd_pkg::CH_SPACE};
							res.rev   = cur.rev;
							res.trow  = cur.row;
							res.tcol  = nxt.col;
						end
					end
					tccd_pkg::CH_FF: begin
						nxt.row = '0;
						nxt.col = '0;
						res.op  = tccd_pkg::OP_CLEAR;
					end
					tccd_pkg::CH_HOME: begin
						nxt.row = '0;
						nxt.col = '0;
						res.op  = tccd_pkg::OP_MOVE;
					end
					tccd_pkg::CH_SCROLL_UP: res.op = tccd_pkg::OP_SCROLL_UP;
					tccd_pkg::CH_SCROLL_DN: res.op = tccd_pkg::OP_SCROLL_DOWN;
					tccd_pkg::CH_UP: begin
						if (cur.row != '0)
							nxt.row = cur.row - 1'b1;
						res.op   = tccd_pkg::OP_MOVE;
						res.trow = nxt.row;
						res.tcol = cur.col;
					end
					tccd_pkg::CH_DOWN: begin
						nxt.row  = (row_inc < ROWS_X) ? row_inc[RW-1:0] : LAST_ROW;
						res.op   = tccd_pkg::OP_MOVE;
						res.trow = nxt.row;
						res.tcol = cur.col;
					end
					tccd_pkg::CH_RIGHT: begin
						nxt.col  = (col_inc < COLS_X) ? col_inc[CW-1:0]
						         : LAST_COL_X[CW-1:0];
						res.op   = tccd_pkg::OP_MOVE;
						res.trow = cur.row;
						res.tcol = nxt.col;
					end
					tccd_pkg::CH_LEFT: begin
						if (cur.col != '0)
							nxt.col = cur.col - 1'b1;
						res.op   = tccd_pkg::OP_MOVE;
						res.trow = cur.row;
						res.tcol = nxt.col;
					end
					tccd_pkg::CH_ESC: nxt.esc_count = tccd_pkg::ESC_SECOND;
					tccd_pkg::CH_LF: begin
						// On the last row the screen scrolls and the cursor returns to column 0.
						if (cur.row == LAST_ROW) begin
							nxt.col = '0;
							res.op  = tccd_pkg::OP_SCROLL_UP;
						end else begin
							nxt.row  = row_inc[RW-1:0];
							res.op   = tccd_pkg::OP_MOVE;
							res.trow = nxt.row;
							res.tcol = cur.col;
						end
					end
					tccd_pkg::CH_CR: begin
						nxt.col  = '0;
						res.op   = tccd_pkg::OP_MOVE;
						res.trow = cur.row;
					end
					default: ;
				endcase
			end else begin
				res.op = tccd_pkg::OP_PRINT;
				if (cur.natl && nat.hit)
					res.glyph = tccd_pkg::GLYPH_NATIONAL_BASE + {5'd0, nat.idx};
				else if (v == tccd_pkg::CH_DEL)
					res.glyph = tccd_pkg::GLYPH_ARROW;
				else
					res.glyph = {1'b0, v};
				res.rev  = cur.rev;
				res.trow = cur.row;
				res.tcol = cur.col;
				// The cursor wraps after a print in the next-to-last column, so printing never moves it into the last column.
				if (col_inc >= LAST_COL_X) begin
					if (cur.row >= LAST_ROW)
						res.op = tccd_pkg::OP_PRINT_SCROLL;
					else
						nxt.row = row_inc[RW-1:0];
					nxt.col = '0;
				end else begin
					nxt.col = col_inc[CW-1:0];
				end
			end
		end
		res.new_row = nxt.row;
		res.new_col = nxt.col;
		res.shown   = nxt.cur_en && (nxt.esc_count == tccd_pkg::ESC_IDLE);
	end

endmodule
